### rtl/core/b64e_pkg.sv
// Package for the base64 stream encoder.
// Holds the queue entry type, phase codes, character constants and the symbol map.
// No dependencies.
package b64e_pkg;

    // Queue depth between the front and the back
    localparam int unsigned QUEUE_DEPTH = 4;

    // Characters per byte at most: a final byte opening a group
    localparam int unsigned MAX_CHARS = 4;

    // Byte position within the current three-byte group
    localparam logic [1:0] PHASE_FIRST  = 2'd0;
    localparam logic [1:0] PHASE_SECOND = 2'd1;
    localparam logic [1:0] PHASE_THIRD  = 2'd2;

    localparam logic [7:0] PAD_CHAR   = 8'h3d;
    localparam logic [7:0] UPPER_BASE = 8'h41;
    localparam logic [7:0] LOWER_BASE = 8'h61;
    localparam logic [7:0] DIGIT_BASE = 8'h30;
    localparam logic [7:0] PLUS_CHAR  = 8'h2b;
    localparam logic [7:0] SLASH_CHAR = 8'h2f;

    // One classified input byte: the characters it makes and how many
    typedef struct packed {
        logic [MAX_CHARS-1:0][7:0] chars;
        logic [2:0]                count;
        logic                      last;
    } entry_t;

    // Map a six-bit symbol to its ASCII character
    function automatic logic [7:0] sym(input logic [5:0] v);
        logic [7:0] v8;
        v8 = {2'b00, v};
        if (v < 6'd26) begin
            sym = UPPER_BASE + v8;
        end else if (v < 6'd52) begin
            sym = LOWER_BASE + (v8 - 8'd26);
        end else if (v < 6'd62) begin
            sym = DIGIT_BASE + (v8 - 8'd52);
        end else if (v == 6'd62) begin
            sym = PLUS_CHAR;
        end else begin
            sym = SLASH_CHAR;
        end
    endfunction

endpackage

### rtl/core/b64e_front.sv
// Front part of the base64 encoder: accepts bytes and turns each into a queue entry.
// Keeps the group phase and the leftover bits. Depends on b64e_pkg.
module b64e_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] data_byte
    input  logic              s_tlast,
    input  logic              queue_full,
    output logic              push,
    output b64e_pkg::entry_t  entry
);

    logic [1:0] phase_reg, phase_next;
    logic [3:0] left_reg, left_next;

    assign s_tready = !queue_full;
    assign push     = s_tvalid && s_tready;

    // Classify the byte by phase and build its characters
    always_comb begin
        phase_next  = phase_reg;
        left_next   = left_reg;
        entry.chars = {b64e_pkg::MAX_CHARS{b64e_pkg::PAD_CHAR}};
        entry.count = 3'd1;
        entry.last  = s_tlast;
        case (phase_reg)
            b64e_pkg::PHASE_SECOND: begin
                entry.chars[0] = b64e_pkg::sym({left_reg[1:0], s_tdata[7:4]});
                if (s_tlast) begin
                    entry.chars[1] = b64e_pkg::sym({s_tdata[3:0], 2'b00});
                    entry.count    = 3'd3;
                    phase_next     = b64e_pkg::PHASE_FIRST;
                    left_next      = 4'd0;
                end else begin
                    phase_next = b64e_pkg::PHASE_THIRD;
                    left_next  = s_tdata[3:0];
                end
            end
            b64e_pkg::PHASE_THIRD: begin
                entry.chars[0] = b64e_pkg::sym({left_reg, s_tdata[7:6]});
                entry.chars[1] = b64e_pkg::sym(s_tdata[5:0]);
                entry.count    = 3'd2;
                phase_next     = b64e_pkg::PHASE_FIRST;
                left_next      = 4'd0;
            end
            default: begin
                entry.chars[0] = b64e_pkg::sym(s_tdata[7:2]);
                if (s_tlast) begin
                    entry.chars[1] = b64e_pkg::sym({s_tdata[1:0], 4'b0000});
                    entry.count    = 3'd4;
                    phase_next     = b64e_pkg::PHASE_FIRST;
                    left_next      = 4'd0;
                end else begin
                    phase_next = b64e_pkg::PHASE_SECOND;
                    left_next  = {2'b00, s_tdata[1:0]};
                end
            end
        endcase
    end

    // Advance phase on each accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= b64e_pkg::PHASE_FIRST;
            left_reg  <= 4'd0;
        end else if (push) begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
        end
    end

    phase_valid_a: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != 2'd3)
        else $error("group phase reached unused value");

    last_clears_a: assert property (@(posedge aclk) disable iff (!aresetn)
        push && s_tlast |=> phase_reg == b64e_pkg::PHASE_FIRST && left_reg == 4'd0)
        else $error("phase not cleared after last byte");

    third_count_a: assert property (@(posedge aclk) disable iff (!aresetn)
        push && phase_reg == b64e_pkg::PHASE_THIRD |-> entry.count == 3'd2)
        else $error("third byte must give two characters");

endmodule

### rtl/core/b64e_fifo.sv
// Short queue of classified entries between the front and the back.
// Register storage with head read by pointer. Depends on b64e_pkg.
module b64e_fifo #(
    parameter int unsigned DEPTH = b64e_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  b64e_pkg::entry_t  push_entry,
    input  logic              pop,
    output b64e_pkg::entry_t  head,
    output logic              empty,
    output logic              full
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    b64e_pkg::entry_t   store_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign empty = (count_reg == CNT_W'(0));
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign head  = store_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    // Write new entries at the tail
    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    no_overflow_a: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("push into full queue");

    no_underflow_a: assert property (@(posedge aclk) disable iff (!aresetn)
        empty |-> !pop)
        else $error("pop from empty queue");

    count_bound_a: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue occupancy out of range");

endmodule

### rtl/core/b64e_back.sv
// Back part of the base64 encoder: sends the characters of each queue entry, one per
// cycle into a registered output while m_tready is high. Depends on b64e_pkg.
module b64e_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  b64e_pkg::entry_t  head,
    input  logic              queue_empty,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // [7:0] out_char
    output logic              m_tlast
);

    logic [1:0] idx_reg;
    logic       m_tvalid_reg;
    logic [7:0] m_tdata_reg;
    logic       m_tlast_reg;
    logic       load;
    logic       final_char;

    assign load       = !queue_empty && (!m_tvalid_reg || m_tready);
    assign final_char = ({1'b0, idx_reg} == head.count - 3'd1);
    assign pop        = load && final_char;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // Hold output until taken; step through the head entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            idx_reg      <= 2'd0;
        end else begin
            if (load) begin
                m_tvalid_reg <= 1'b1;
                idx_reg      <= final_char ? 2'd0 : idx_reg + 2'd1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (load) begin
            m_tdata_reg <= head.chars[idx_reg];
            m_tlast_reg <= head.last && final_char;
        end
    end

    idle_index_a: assert property (@(posedge aclk) disable iff (!aresetn)
        queue_empty |-> idx_reg == 2'd0)
        else $error("character index left inside missing entry");

    index_bound_a: assert property (@(posedge aclk) disable iff (!aresetn)
        !queue_empty |-> {1'b0, idx_reg} < head.count)
        else $error("character index past entry count");

    stall_hold_a: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !m_tready |=> m_tvalid_reg && $stable(m_tdata_reg))
        else $error("stalled character changed");

endmodule

### rtl/core/base64_stream_encoder_top.sv
// Top level of the base64 stream encoder (A-Z a-z 0-9 + / alphabet, '=' padding).
// Instantiates b64e_front, b64e_fifo and b64e_back; depends on b64e_pkg.
//
//  channel  | direction | handshake          | tdata          | tlast
//  ---------+-----------+--------------------+----------------+----------------
//  s_       | in        | s_tvalid/s_tready  | [7:0] data_byte| is_last
//  m_       | out       | m_tvalid/m_tready  | [7:0] out_char | end_of_message
//
// Output runs at one character per cycle while m_tready is high and an entry waits,
// from the single output register of the back part. A byte gives 1 to 4 characters:
// 1 inside a group, 2 as a third byte, 3 or 4 as a final byte; 4 per 3 in long runs.
// Input is accepted every cycle while the QUEUE_DEPTH-entry queue has room.
// Reset (aresetn low, synchronous) empties the queue and restarts the group.
// A low m_tready holds the character; the queue then fills and drops s_tready.
module base64_stream_encoder_top #(
    parameter int unsigned QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic       m_tlast
);

    b64e_pkg::entry_t push_entry;
    b64e_pkg::entry_t head;
    logic             push;
    logic             pop;
    logic             queue_empty;
    logic             queue_full;

    b64e_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .queue_full (queue_full),
        .push       (push),
        .entry      (push_entry)
    );

    b64e_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (queue_empty),
        .full       (queue_full)
    );

    b64e_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head        (head),
        .queue_empty (queue_empty),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule
